// ----- rtl/core/dcdt_pkg.sv -----
// ----------------------------------------------------------------------------
// dcdt_pkg
// Shared types for the deadline table: command kinds, the queued item, the queue head and back states.
// ----------------------------------------------------------------------------
`default_nettype none

package dcdt_pkg;

  typedef enum logic [1:0] {
    K_SCHED  = 2'd0,
    K_POLL   = 2'd1,
    K_CANCEL = 2'd2,
    K_NONE   = 2'd3
  } kind_t;

  // one item as it travels from front to back
  typedef struct packed {
    kind_t       kind;
    logic [15:0] task_id;
    logic [63:0] delay;
    logic [63:0] now_us;
  } item_t;

  // front-to-back queue head
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EVAL = 2'd2
  } bstate_t;

  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/core/dcdt_ram.sv -----
// ----------------------------------------------------------------------------
// dcdt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/dcdt_front.sv -----
// ----------------------------------------------------------------------------
// dcdt_front
// Accepts items, classifies the kind and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdt_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [1:0]      in_kind,
  input  wire logic [15:0]     in_task_id,
  input  wire logic [63:0]     in_delay_us,
  input  wire logic [63:0]     in_now_us,
  output dcdt_pkg::qhead_t     q_head,
  input  wire logic            q_pop
);
  import dcdt_pkg::*;

  item_t      slot_r [2];
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item_in;

  // classify incoming kind
  always_comb begin
    item_in.task_id = in_task_id;
    item_in.delay   = in_delay_us;
    item_in.now_us  = in_now_us;
    item_in.kind    = kind_t'(in_kind);
  end

  assign busy = (cnt_r == 2'd2);
  assign push = start && !busy;
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.item  = slot_r[rd_r];

  // queue pointers
  always_comb begin
    rd_nxt  = rd_r;
    wr_nxt  = wr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = ~wr_r;
    end
    if (q_pop && q_head.valid) begin
      rd_nxt = ~rd_r;
    end
    if (push && !(q_pop && q_head.valid)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push && q_pop && q_head.valid) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= item_in;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dcdt_back.sv -----
// ----------------------------------------------------------------------------
// dcdt_back
// Executes queued items against the table memory: append, scan and compact.
// ----------------------------------------------------------------------------
`default_nettype none

module dcdt_back #(
  parameter int TABLE_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire dcdt_pkg::qhead_t     q_head,
  output logic                      q_pop,
  output logic                      res_valid,
  output logic                      res_accepted,
  output logic                      res_fired,
  output logic [TASK_BITS-1:0]      res_task,
  output logic [63:0]               res_sleep_us
);
  import dcdt_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = TASK_BITS + 64;

  bstate_t          state_r, state_nxt;
  item_t            cur_r, cur_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    i_r, i_nxt;
  logic [CW-1:0]    w_r, w_nxt;
  logic             fired_r, fired_nxt;
  logic [TASK_BITS-1:0] ftask_r, ftask_nxt;
  logic [63:0]      sleep_r, sleep_nxt;

  logic             ov_r, ov_nxt;
  logic             oacc_r, oacc_nxt;
  logic             ofired_r, ofired_nxt;
  logic [TASK_BITS-1:0] otask_r, otask_nxt;
  logic [63:0]      osleep_r, osleep_nxt;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  logic [EW-1:0]    wdata, rdata;

  logic [31:0]          tid_ext, cur_ext;
  logic [TASK_BITS-1:0] in_task, cur_task, rd_task;
  logic [63:0]      rd_due, diff;
  logic             expired, drop;
  logic [CW-1:0]    i_inc, w_inc;

  dcdt_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // handle in TASK_BITS
  assign tid_ext  = {16'd0, q_head.item.task_id};
  assign in_task  = tid_ext[TASK_BITS-1:0];
  assign cur_ext  = {16'd0, cur_r.task_id};
  assign cur_task = cur_ext[TASK_BITS-1:0];

  assign rd_due  = rdata[63:0];
  assign rd_task = rdata[64 +: TASK_BITS];
  assign diff    = rd_due - cur_r.now_us;
  assign expired = (cur_r.now_us >= rd_due);
  assign i_inc   = i_r + CW'(1);
  assign w_inc   = w_r + CW'(1);

  always_comb begin
    drop = 1'b0;
    case (cur_r.kind)
      K_POLL:   drop = !fired_r && expired;
      K_CANCEL: drop = (rd_task == cur_task);
      default:  drop = 1'b0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    count_nxt  = count_r;
    i_nxt      = i_r;
    w_nxt      = w_r;
    fired_nxt  = fired_r;
    ftask_nxt  = ftask_r;
    sleep_nxt  = sleep_r;
    ov_nxt     = 1'b0;
    oacc_nxt   = 1'b0;
    ofired_nxt = 1'b0;
    otask_nxt  = '0;
    osleep_nxt = '0;
    q_pop      = 1'b0;
    we         = 1'b0;
    waddr      = w_r[AW-1:0];
    wdata      = rdata;
    raddr      = i_r[AW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_head.item;
          i_nxt   = '0;
          w_nxt   = '0;
          fired_nxt = 1'b0;
          ftask_nxt = '0;
          sleep_nxt = ALL_ONES;
          case (q_head.item.kind)
            K_SCHED: begin
              ov_nxt = 1'b1;
              if (count_r < CW'(TABLE_DEPTH)) begin
                we        = 1'b1;
                waddr     = count_r[AW-1:0];
                wdata     = {in_task, q_head.item.now_us + q_head.item.delay};
                count_nxt = count_r + CW'(1);
                oacc_nxt  = 1'b1;
              end
            end
            K_POLL: begin
              if (count_r == '0) begin
                ov_nxt     = 1'b1;
                osleep_nxt = ALL_ONES;
              end else begin
                state_nxt = ST_READ;
              end
            end
            K_CANCEL: begin
              if (count_r == '0) begin
                ov_nxt = 1'b1;
              end else begin
                state_nxt = ST_READ;
              end
            end
            default: begin
              ov_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        raddr     = i_r[AW-1:0];
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        raddr = i_inc[AW-1:0];
        i_nxt = i_inc;
        if (drop) begin
          if (cur_r.kind == K_POLL) begin
            fired_nxt = 1'b1;
            ftask_nxt = rd_task;
            sleep_nxt = '0;
          end
        end else begin
          we    = 1'b1;
          w_nxt = w_inc;
          if (cur_r.kind == K_POLL && !fired_r && diff < sleep_r) begin
            sleep_nxt = diff;
          end
        end
        if (i_inc == count_r) begin
          state_nxt = ST_IDLE;
          count_nxt = w_nxt;
          ov_nxt    = 1'b1;
          if (cur_r.kind == K_POLL) begin
            ofired_nxt = fired_nxt;
            otask_nxt  = ftask_nxt;
            osleep_nxt = sleep_nxt;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    cur_r    <= cur_nxt;
    i_r      <= i_nxt;
    w_r      <= w_nxt;
    fired_r  <= fired_nxt;
    ftask_r  <= ftask_nxt;
    sleep_r  <= sleep_nxt;
    oacc_r   <= oacc_nxt;
    ofired_r <= ofired_nxt;
    otask_r  <= otask_nxt;
    osleep_r <= osleep_nxt;
  end

  assign res_valid    = ov_r;
  assign res_accepted = oacc_r;
  assign res_fired    = ofired_r;
  assign res_task     = otask_r;
  assign res_sleep_us = osleep_r;

endmodule

`default_nettype wire

// ----- rtl/core/deferred_call_deadline_table.sv -----
// ----------------------------------------------------------------------------
// deferred_call_deadline_table
// Ordered table of pending tasks with due times: schedule, poll and cancel.
// ----------------------------------------------------------------------------
// Usage:
//   Input items are taken when start is high and busy is low. in_kind selects
//   schedule, poll or cancel; in_now_us is the current time.
//   Every item yields exactly one result, shown for one cycle with out_valid.
//   The receiver cannot stall; results leave in item order.
// Operation:
//   A front queue of two items decouples input from execution.
//   Schedule, unknown kinds, and poll or cancel on an empty table are
//   answered from the queue head through the registered result. Otherwise
//   poll and cancel go through a read state and then evaluate states that
//   scan and compact the single-read-port table memory one entry a cycle;
//   the back part takes no new item until that scan is done, while the
//   front queue keeps accepting items until it is full.
// Reset:
//   Synchronous active-low rst_n empties the table and the queue at once;
//   the table memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_call_deadline_table #(
  parameter int TABLE_DEPTH = 16,
  parameter int TASK_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [15:0] in_task_id,
  input  wire logic [63:0] in_delay_us,
  input  wire logic [63:0] in_now_us,
  output logic             out_valid,
  output logic             out_accepted,
  output logic             out_fired,
  output logic [15:0]      out_fired_task,
  output logic [63:0]      out_sleep_us
);
  import dcdt_pkg::*;

  qhead_t               q_head;
  logic                 q_pop;
  logic [TASK_BITS-1:0] res_task;
  logic [31:0]          task_ext;

  dcdt_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_task_id  (in_task_id),
    .in_delay_us (in_delay_us),
    .in_now_us   (in_now_us),
    .q_head      (q_head),
    .q_pop       (q_pop)
  );

  dcdt_back #(.TABLE_DEPTH(TABLE_DEPTH), .TASK_BITS(TASK_BITS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .res_valid    (out_valid),
    .res_accepted (out_accepted),
    .res_fired    (out_fired),
    .res_task     (res_task),
    .res_sleep_us (out_sleep_us)
  );

  // handle reported in 16 bits
  assign task_ext       = 32'(res_task);
  assign out_fired_task = task_ext[15:0];

endmodule

`default_nettype wire
